[src/udarp_pkg.sv]
// udarp_pkg: shared types, constants and priority-encode helpers of the
// up/down arpeggiator. No dependencies.
`default_nettype none

package udarp_pkg;

  localparam int PITCH_COUNT = 128;
  localparam int TICK_BITS   = 32;
  localparam int PITCH_W     = (PITCH_COUNT > 1) ? $clog2(PITCH_COUNT) : 1;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  localparam logic [1:0] REG_STEP_TICKS = 2'd0;
  localparam logic [1:0] REG_GATE_TICKS = 2'd1;

  localparam logic [4:0]  DRUM_CHANNEL   = 5'd10;
  localparam logic [6:0]  VEL_LOWEST     = 7'd108;
  localparam logic [6:0]  VEL_OTHER      = 7'd92;
  localparam logic [15:0] STEP_TICKS_RST = 16'd240;
  localparam logic [15:0] GATE_TICKS_RST = 16'd196;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] note_pitch;
    logic [4:0] note_channel;
  } in_item_t;

  typedef struct packed {
    logic [31:0] start_tick;
    logic [15:0] length_ticks;
    logic [6:0]  out_pitch;
    logic [6:0]  out_velocity;
    logic        no_pitches;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic pick;
    logic emit_note;
    logic emit_empty;
  } dp_cmd_t;

  typedef struct packed {
    logic set_empty;
  } dp_sts_t;

  typedef struct packed {
    logic               found;
    logic [PITCH_W-1:0] idx;
  } find_t;

  // lowest set bit
  function automatic find_t find_lowest(input logic [PITCH_COUNT-1:0] m);
    find_t r;
    r.found = |m;
    r.idx   = '0;
    for (int i = PITCH_COUNT - 1; i >= 0; i--) begin
      if (m[i]) r.idx = PITCH_W'(i);
    end
    return r;
  endfunction

  // highest set bit
  function automatic find_t find_highest(input logic [PITCH_COUNT-1:0] m);
    find_t r;
    r.found = |m;
    r.idx   = '0;
    for (int i = 0; i < PITCH_COUNT; i++) begin
      if (m[i]) r.idx = PITCH_W'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/up_down_arpeggiator_unit.sv]
// up_down_arpeggiator_unit: top level joining controller and datapath.
// Depends on udarp_pkg, udarp_ctrl, udarp_datapath.
//
//   channel   | handshake                      | payload
//   ----------+--------------------------------+-----------------------------
//   command   | start / busy                   | item_i (in_item_t)
//   result    | result_valid_o (1-cycle pulse) | result_o (out_item_t)
//   config    | cfg_valid_i / cfg_ready_o      | cfg_index_i, cfg_data_i
//
// load and clear leave busy low; the next command can follow at once. a
// step holds busy through the set search and then the walk update, and its
// result strobes after the walk update; busy is low again then, so the next
// command can be taken at the same edge that takes the result.
// the set search is a priority encode over the pitch set.
// reset empties the set and loads the default step and gate lengths.
// the result side has no stall; each result is strobed for one cycle only.
`default_nettype none

module up_down_arpeggiator_unit
  import udarp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    item_i,
  output logic             result_valid_o,
  output out_item_t        result_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  udarp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .op_i           (item_i.op),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  udarp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sts_o       (sts),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

[src/udarp_ctrl.sv]
// udarp_ctrl: sequencing state machine of the arpeggiator.
// Depends on udarp_pkg; drives commands into udarp_datapath.
`default_nettype none

module udarp_ctrl
  import udarp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire logic     [1:0] op_i,
  input  wire dp_sts_t  sts_i,
  output dp_cmd_t       cmd_o,
  output logic          busy,
  output logic          result_valid_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;
  logic   accept;

  assign accept = start && !busy_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = accept && (op_i == OP_LOAD);
    cmd_o.clear      = accept && (op_i == OP_CLEAR);
    cmd_o.pick       = (state_q == S_PICK);
    cmd_o.emit_note  = (state_q == S_EMIT) && !sts_i.set_empty;
    cmd_o.emit_empty = (state_q == S_EMIT) && sts_i.set_empty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept && (op_i == OP_STEP)) begin
            state_q <= S_PICK;
            busy_q  <= 1'b1;
          end
        end
        S_PICK: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy           = busy_q;
  assign result_valid_o = done_q;

endmodule

`default_nettype wire

[src/udarp_datapath.sv]
// udarp_datapath: pitch set, walk position, tick counter, config registers
// and result register. Depends on udarp_pkg; commanded by udarp_ctrl.
`default_nettype none

module udarp_datapath
  import udarp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire dp_cmd_t    cmd_i,
  input  wire in_item_t   item_i,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output dp_sts_t         sts_o,
  output out_item_t       result_o
);

  logic [PITCH_COUNT-1:0] set_q;
  logic [PITCH_W-1:0]     next_q, cur_q, lowest_q;
  logic                   going_down_q, started_q, empty_q;
  logic [TICK_BITS-1:0]   tick_q;
  logic [15:0]            step_q, gate_q;
  out_item_t              res_q;

  find_t                  low, above, below;
  logic [PITCH_COUNT-1:0] above_m, below_m;
  logic                   next_live;
  logic [63:0]            tick_ext;

  assign low       = find_lowest(set_q);
  assign next_live = started_q && set_q[next_q];
  assign tick_ext  = 64'(tick_q);

  // neighbors of the current pitch in either direction
  always_comb begin
    for (int i = 0; i < PITCH_COUNT; i++) begin
      above_m[i] = set_q[i] && (PITCH_W'(i) > cur_q);
      below_m[i] = set_q[i] && (PITCH_W'(i) < cur_q);
    end
  end

  assign above = find_lowest(above_m);
  assign below = find_highest(below_m);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q        <= '0;
      next_q       <= '0;
      cur_q        <= '0;
      lowest_q     <= '0;
      going_down_q <= 1'b0;
      started_q    <= 1'b0;
      tick_q       <= '0;
      empty_q      <= 1'b1;
      step_q       <= STEP_TICKS_RST;
      gate_q       <= GATE_TICKS_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_STEP_TICKS: step_q <= cfg_data_i;
          REG_GATE_TICKS: gate_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load && (item_i.note_channel != DRUM_CHANNEL) &&
          (32'(item_i.note_pitch) < PITCH_COUNT)) begin
        set_q[item_i.note_pitch[PITCH_W-1:0]] <= 1'b1;
      end
      if (cmd_i.clear) begin
        set_q        <= '0;
        next_q       <= '0;
        going_down_q <= 1'b0;
        started_q    <= 1'b0;
        tick_q       <= '0;
      end
      if (cmd_i.pick) begin
        empty_q  <= !low.found;
        lowest_q <= low.idx;
        // restart from the lowest pitch when the walk has not started or its target is gone
        if (low.found && !next_live) begin
          cur_q        <= low.idx;
          going_down_q <= 1'b0;
          started_q    <= 1'b1;
        end else begin
          cur_q <= next_q;
        end
      end
      if (cmd_i.emit_note) begin
        if (going_down_q) begin
          if (below.found)      next_q <= below.idx;
          else if (above.found) begin
            next_q       <= above.idx;
            going_down_q <= 1'b0;
          end else              next_q <= cur_q;
        end else begin
          if (above.found)      next_q <= above.idx;
          else if (below.found) begin
            next_q       <= below.idx;
            going_down_q <= 1'b1;
          end else              next_q <= cur_q;
        end
        tick_q <= tick_q + TICK_BITS'(step_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_note) begin
      res_q.start_tick   <= tick_ext[31:0];
      res_q.length_ticks <= gate_q;
      res_q.out_pitch    <= 7'(cur_q);
      res_q.out_velocity <= (cur_q == lowest_q) ? VEL_LOWEST : VEL_OTHER;
      res_q.no_pitches   <= 1'b0;
    end else if (cmd_i.emit_empty) begin
      res_q.start_tick   <= '0;
      res_q.length_ticks <= '0;
      res_q.out_pitch    <= '0;
      res_q.out_velocity <= '0;
      res_q.no_pitches   <= 1'b1;
    end
  end

  assign sts_o.set_empty = empty_q;
  assign result_o        = res_q;

endmodule

`default_nettype wire

[src/udarp_checker.sv]
// udarp_checker: port-level timing checks for up_down_arpeggiator_unit.
// Depends on udarp_pkg; attached to the top level by the bind below.
`default_nettype none

module udarp_checker
  import udarp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire in_item_t    item_i,
  input wire logic        result_valid_o,
  input wire out_item_t   result_o
);

  logic step_xfer, quick_xfer;

  assign step_xfer  = start && !busy && (item_i.op == OP_STEP);
  assign quick_xfer = start && !busy && (item_i.op == OP_LOAD || item_i.op == OP_CLEAR);

  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_xfer |-> ##3 result_valid_o)
    else $error("step transfer without result three cycles later");

  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_xfer |=> busy)
    else $error("busy not raised after step transfer");

  a_quick_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quick_xfer |=> !busy)
    else $error("busy raised after load or clear");

  a_result_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("results on consecutive cycles");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.no_pitches) |->
      (result_o.start_tick == '0 && result_o.out_pitch == '0))
    else $error("empty-set result carries note data");

endmodule

bind up_down_arpeggiator_unit udarp_checker u_udarp_checker (.*);

`default_nettype wire

[tb/testbench.sv]
// testbench: self-checking bench for up_down_arpeggiator_unit, with an
// in-bench model of the pitch set, the ping-pong walk and the tick counter.
// Depends on udarp_pkg and up_down_arpeggiator_unit.
`timescale 1ns / 1ps

module testbench;
  import udarp_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT = 200;
  localparam int         SETTLE      = 6;
  localparam int         PHASES      = 6;
  localparam int         PHASE_ITEMS = 300;
  localparam int         WRAP_STEPS  = 20;

  typedef struct {
    in_item_t  cmd;
    bit        typed;
    out_item_t want;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        cmd_start;
  logic        busy;
  in_item_t    cmd_item;
  logic        res_valid;
  out_item_t   res_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // model state
  bit [PITCH_COUNT-1:0]  held = '0;
  logic [6:0]            walk_pitch = '0;
  bit                    walk_down = 1'b0;
  bit                    walk_live = 1'b0;
  logic [TICK_BITS-1:0]  tick_pos = '0;
  logic [15:0]           step_len = STEP_TICKS_RST;
  logic [15:0]           gate_len = GATE_TICKS_RST;

  out_item_t notes_due[$];
  bit        use_typed = 1'b0;
  out_item_t typed_note = '0;

  int unsigned cmds_taken = 0;
  int unsigned cfg_taken = 0;
  int unsigned notes_seen = 0;
  int unsigned empty_seen = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  up_down_arpeggiator_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (cmd_start),
    .busy           (busy),
    .item_i         (cmd_item),
    .result_valid_o (res_valid),
    .result_o       (res_item),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic int nearest_above(input int p);
    int i;
    for (i = p + 1; i < PITCH_COUNT; i++) begin
      if (held[i]) return i;
    end
    return -1;
  endfunction

  function automatic int nearest_below(input int p);
    int i;
    for (i = p - 1; i >= 0; i--) begin
      if (held[i]) return i;
    end
    return -1;
  endfunction

  // advance the model by one command, giving the note it should produce
  task automatic arp_predict(input in_item_t c, output bit has_note, output out_item_t note);
    int lowest, cur, nxt;
    has_note = 1'b0;
    note = '0;
    case (c.op)
      OP_LOAD: begin
        if (c.note_channel != DRUM_CHANNEL) held[c.note_pitch] = 1'b1;
      end
      OP_CLEAR: begin
        held = '0;
        walk_pitch = '0;
        walk_down = 1'b0;
        walk_live = 1'b0;
        tick_pos = '0;
      end
      OP_STEP: begin
        has_note = 1'b1;
        lowest = nearest_above(-1);
        if (lowest < 0) begin
          note.no_pitches = 1'b1;
        end else begin
          if (!walk_live || !held[walk_pitch]) begin
            cur = lowest;
            walk_down = 1'b0;
            walk_live = 1'b1;
          end else begin
            cur = int'(walk_pitch);
          end
          note.start_tick   = tick_pos[31:0];
          note.length_ticks = gate_len;
          note.out_pitch    = 7'(cur);
          note.out_velocity = (cur == lowest) ? VEL_LOWEST : VEL_OTHER;
          // turn around at either end of the set
          if (walk_down) begin
            nxt = nearest_below(cur);
            if (nxt < 0) begin
              nxt = nearest_above(cur);
              if (nxt >= 0) walk_down = 1'b0;
            end
          end else begin
            nxt = nearest_above(cur);
            if (nxt < 0) begin
              nxt = nearest_below(cur);
              if (nxt >= 0) walk_down = 1'b1;
            end
          end
          walk_pitch = (nxt < 0) ? 7'(cur) : 7'(nxt);
          tick_pos = tick_pos + TICK_BITS'(step_len);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_note(input out_item_t got);
    out_item_t want;
    if (notes_due.size() == 0) begin
      report("result with nothing expected");
    end else begin
      want = notes_due.pop_front();
      if (got.start_tick !== want.start_tick)
        report($sformatf("start_tick got %0d want %0d", got.start_tick, want.start_tick));
      if (got.length_ticks !== want.length_ticks)
        report($sformatf("length_ticks got %0d want %0d", got.length_ticks,
                         want.length_ticks));
      if (got.out_pitch !== want.out_pitch)
        report($sformatf("out_pitch got %0d want %0d", got.out_pitch, want.out_pitch));
      if (got.out_velocity !== want.out_velocity)
        report($sformatf("out_velocity got %0d want %0d", got.out_velocity,
                         want.out_velocity));
      if (got.no_pitches !== want.no_pitches)
        report($sformatf("no_pitches got %0b want %0b", got.no_pitches, want.no_pitches));
    end
  endtask

  // sample every transfer at the rising edge
  always @(posedge clk) begin : monitor
    bit        has_note;
    out_item_t note;
    bit        moved;
    if (rst_n) begin
      moved = 1'b0;
      if (res_valid) begin
        moved = 1'b1;
        notes_seen++;
        if (res_item.no_pitches === 1'b1) empty_seen++;
        check_note(res_item);
      end
      if (cmd_start && !busy) begin
        moved = 1'b1;
        arp_predict(cmd_item, has_note, note);
        if (has_note) notes_due = {notes_due, (use_typed ? typed_note : note)};
        cmds_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          REG_STEP_TICKS: step_len = cfg_data;
          REG_GATE_TICKS: gate_len = cfg_data;
          default: ;
        endcase
        cfg_taken++;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_cmd(input in_item_t c, input int unsigned gap, input bit typed,
                          input out_item_t want);
    int unsigned seen;
    if (gap != 0) begin
      cmd_start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    use_typed = typed;
    typed_note = want;
    cmd_item <= c;
    cmd_start <= 1'b1;
    seen = cmds_taken;
    do @(negedge clk); while (cmds_taken == seen);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    int unsigned seen;
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    seen = cfg_taken;
    do @(negedge clk); while (cfg_taken == seen);
    cfg_valid <= 1'b0;
  endtask

  // drain all pending notes, then give the block time to finish loads and clears
  task automatic quiesce();
    cmd_start <= 1'b0;
    while (notes_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic in_item_t mk_cmd(input logic [1:0] op, input int p, input int ch);
    in_item_t c;
    c.op = op;
    c.note_pitch = 7'(p);
    c.note_channel = 5'(ch);
    return c;
  endfunction

  function automatic out_item_t mk_note(input int unsigned tick, input int len, input int p,
                                        input logic [6:0] vel, input bit empty);
    out_item_t n;
    n.start_tick = tick;
    n.length_ticks = 16'(len);
    n.out_pitch = 7'(p);
    n.out_velocity = vel;
    n.no_pitches = empty;
    return n;
  endfunction

  function automatic plan_row_t row(input logic [1:0] op, input int p, input int ch,
                                    input bit typed = 1'b0, input out_item_t want = '0);
    plan_row_t r;
    r.cmd = mk_cmd(op, p, ch);
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // mostly loads and steps with random content, some clears, drums and dead ops
  function automatic in_item_t rand_cmd();
    in_item_t c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    c.note_pitch = 7'($urandom_range(0, 127));
    c.note_channel = 5'($urandom_range(0, 31));
    if (pick < 40) begin
      c.op = OP_LOAD;
    end else if (pick < 44) begin
      c.op = OP_LOAD;
      c.note_channel = DRUM_CHANNEL;
    end else if (pick < 89) begin
      c.op = OP_STEP;
    end else if (pick < 95) begin
      c.op = OP_CLEAR;
    end else begin
      c.op = OP_UNUSED;
    end
    return c;
  endfunction

  initial begin : stimulus
    plan_row_t   plan[$];
    int unsigned gap;
    logic [15:0] step_v, gate_v;
    cmd_start = 1'b0;
    cmd_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    plan = {plan, row(OP_STEP, 0, 1, 1'b1, mk_note(0, 0, 0, 7'd0, 1'b1))};
    plan = {plan, row(OP_LOAD, 0, 1)};
    plan = {plan, row(OP_LOAD, 127, 16)};
    plan = {plan, row(OP_LOAD, 60, DRUM_CHANNEL)};
    plan = {plan, row(OP_LOAD, 60, 0)};
    plan = {plan, row(OP_LOAD, 64, 31)};
    plan = {plan, row(OP_STEP, 0, 0, 1'b1, mk_note(0, 196, 0, VEL_LOWEST, 1'b0))};
    plan = {plan, row(OP_STEP, 0, 0)};
    plan = {plan, row(OP_STEP, 0, 0)};
    plan = {plan, row(OP_STEP, 0, 0)};
    plan = {plan, row(OP_STEP, 0, 0)};
    plan = {plan, row(OP_UNUSED, 45, 3)};
    // 62 lies between the note just played and the next one, so it is passed over
    plan = {plan, row(OP_LOAD, 62, 2)};
    plan = {plan, row(OP_LOAD, 30, 5)};
    plan = {plan, row(OP_STEP, 0, 0)};
    plan = {plan, row(OP_STEP, 0, 0)};
    plan = {plan, row(OP_STEP, 0, 0)};
    plan = {plan, row(OP_STEP, 0, 0)};
    plan = {plan, row(OP_CLEAR, 0, 0)};
    plan = {plan, row(OP_STEP, 0, 0, 1'b1, mk_note(0, 0, 0, 7'd0, 1'b1))};
    plan = {plan, row(OP_LOAD, 127, 16)};
    plan = {plan, row(OP_STEP, 0, 0, 1'b1, mk_note(0, 196, 127, VEL_LOWEST, 1'b0))};
    plan = {plan, row(OP_STEP, 0, 0, 1'b1, mk_note(240, 196, 127, VEL_LOWEST, 1'b0))};
    plan = {plan, row(OP_LOAD, 5, 9)};
    plan = {plan, row(OP_STEP, 0, 0)};
    plan = {plan, row(OP_STEP, 0, 0)};
    foreach (plan[i]) send_cmd(plan[i].cmd, i % 3, plan[i].typed, plan[i].want);
    quiesce();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin step_v = 16'd1;     gate_v = 16'hffff; end
        1: begin step_v = 16'hffff;  gate_v = 16'd0;    end
        2: begin step_v = 16'd0;     gate_v = 16'(~$urandom); end
        default: begin
          step_v = 16'($urandom_range(1, 65535));
          gate_v = 16'($urandom_range(0, 65535));
        end
      endcase
      write_reg(REG_STEP_TICKS, step_v);
      write_reg(REG_GATE_TICKS, gate_v);
      if (ph == 0) write_reg(REG_UNUSED, 16'(~$urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // every third stretch runs back to back
        gap = ((n / 37) % 3 == 0) ? 0 : $urandom_range(0, 18);
        send_cmd(rand_cmd(), gap, 1'b0, '0);
      end
      quiesce();
    end

    // a run of steps at the largest step length
    write_reg(REG_STEP_TICKS, 16'hffff);
    write_reg(REG_GATE_TICKS, GATE_TICKS_RST);
    send_cmd(mk_cmd(OP_CLEAR, 0, 0), 0, 1'b0, '0);
    send_cmd(mk_cmd(OP_LOAD, 100, 4), 0, 1'b0, '0);
    for (int n = 0; n < WRAP_STEPS; n++) send_cmd(mk_cmd(OP_STEP, 0, 0), 0, 1'b0, '0);
    quiesce();

    $display("covered %0d commands and %0d register writes over %0d settings",
             cmds_taken, cfg_taken, PHASES + 2);
    $display("checked %0d notes, %0d of them on an empty set", notes_seen, empty_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
src/udarp_pkg.sv
src/udarp_ctrl.sv
src/udarp_datapath.sv
src/up_down_arpeggiator_unit.sv
src/udarp_checker.sv
tb/testbench.sv
